>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/mavn_pkg.sv
`default_nettype none

package mavn_pkg;

  localparam int MAX_WINDOW_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int DATA_W     = 32;  // sample / result word
  localparam int SUM_W      = 42;  // running sum
  localparam int WL_W       = 11;  // window_length register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMALISE_MODE = 2'd1;

  localparam logic [DATA_W-1:0] MIDSCALE = 32'h7FFF_FFFF;

endpackage

`default_nettype wire

>>> rtl/core/mavn_win_mem.sv
`default_nettype none

module mavn_win_mem #(
  parameter int DEPTH = mavn_pkg::MAX_WINDOW_DEF,
  parameter int WIDTH = mavn_pkg::SAMPLE_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read every cycle, registered
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

>>> rtl/core/mavn_div.sv
`default_nettype none

// Restoring bit-serial divider, one quotient bit per cycle.
module mavn_div #(
  parameter int DIVISOR_W = 11
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [mavn_pkg::SUM_W-1:0]   dividend_i,
  input  wire logic [DIVISOR_W-1:0]         divisor_i,
  output logic                              busy_o,
  output logic      [mavn_pkg::DATA_W-1:0]  quotient_o
);

  localparam int SW    = mavn_pkg::SUM_W;
  localparam int CNT_W = $clog2(SW + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] div_q, div_d;
  logic [SW-1:0]        quo_q, quo_d;

  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W+1:0] diff;
  logic                 borrow;

  assign shifted = {rem_q, quo_q[SW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_q};
  assign borrow  = diff[DIVISOR_W+1];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SW);
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // remainder stays below divisor, so low bits suffice after subtract
      rem_d = borrow ? shifted[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
      quo_d = {quo_q[SW-2:0], ~borrow};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q[mavn_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/moving_average_normaliser_top.sv
// Boxcar moving average / normaliser.
// s_axis: one 32-bit sample word per transfer (low SAMPLE_BITS bits used).
// m_axis: one 32-bit result word per accepted sample: the truncated mean of
//   the window, or in normalise mode 0x7FFFFFFF + sample - mean (mod 2^32).
// cfg: register writes (index 0 window_length, 1 normalise_mode), always
//   ready; writing window_length also empties the window. Write only while
//   the block is idle.
// Timing: a sample is taken when tready is high; the mean comes from a
//   42-step bit-serial divider, and the result enters the output register
//   at the same edge at which tready returns. No new word is taken while
//   the divider works on the last one.
// A held result sits in the output register while the next sample is
//   worked on; if the receiver still stalls when that next result is done,
//   the block waits and keeps tready low.
// Reset: window empty, window_length 1, average mode, no output pending.
//   The window memory is not cleared; entries are written before read.
`default_nettype none

module moving_average_normaliser_top #(
  parameter int MAX_WINDOW  = mavn_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mavn_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [mavn_pkg::DATA_W-1:0]       s_axis_tdata_i,  // sample_value
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic      [mavn_pkg::DATA_W-1:0]       m_axis_tdata_o,  // result_value
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mavn_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mavn_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

`include "assert_macros.svh"

  localparam int DW    = mavn_pkg::DATA_W;
  localparam int SW    = mavn_pkg::SUM_W;
  localparam int WLW   = mavn_pkg::WL_W;
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (CNT_W > WLW) ? CNT_W : WLW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                   state_q, state_d;
  logic [SW-1:0]          sum_q, sum_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [PTR_W-1:0]       oldest_q, oldest_d;
  logic [PTR_W-1:0]       newest_q, newest_d;
  logic [WLW-1:0]         wl_q, wl_d;
  logic                   mode_q, mode_d;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic                   out_valid_q, out_valid_d;
  logic [DW-1:0]          out_data_q, out_data_d;

  logic                   accept, finish, remove;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic [SW-1:0]          sum_add;
  logic [CNT_W-1:0]       fill_inc;
  logic [CMP_W-1:0]       wl_ext, eff_len;
  logic                   div_busy;
  logic [DW-1:0]          div_quo;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [DW-1:0]          result;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_WINDOW - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign sample_in = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign sum_add   = sum_q + SW'(sample_in);
  assign fill_inc  = fill_q + CNT_W'(1);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign finish          = (state_q == ST_DIV) & ~div_busy & (~out_valid_q | m_axis_tready_i);
  assign cfg_ready_o     = 1'b1;

  assign wl_ext  = CMP_W'(wl_q);
  assign eff_len = (wl_q == '0) ? CMP_W'(1) :
                   (wl_ext > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : wl_ext;
  assign remove  = (CMP_W'(fill_q) >= eff_len);

  assign result = mode_q ? (mavn_pkg::MIDSCALE + DW'(sample_q) - div_quo) : div_quo;

  mavn_div #(
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (sum_add),
    .divisor_i  (fill_inc),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  mavn_win_mem #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_BITS)
  ) u_win (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (newest_q),
    .wr_data_i (sample_in),
    .rd_addr_i (oldest_q),
    .rd_data_o (old_sample)
  );

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    fill_d      = fill_q;
    oldest_d    = oldest_q;
    newest_d    = newest_q;
    wl_d        = wl_q;
    mode_d      = mode_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      sample_d = sample_in;
      sum_d    = sum_add;
      fill_d   = fill_inc;
      newest_d = advance(newest_q);
      state_d  = ST_DIV;
    end

    if (finish) begin
      out_valid_d = 1'b1;
      out_data_d  = result;
      state_d     = ST_IDLE;
      // window full: drop the oldest word
      if (remove) begin
        sum_d    = sum_q - SW'(old_sample);
        oldest_d = advance(oldest_q);
        fill_d   = fill_q - CNT_W'(1);
      end
    end

    if (cfg_valid_i) begin
      case (cfg_index_i)
        mavn_pkg::REG_WINDOW_LENGTH: begin
          wl_d     = cfg_data_i[WLW-1:0];
          sum_d    = '0;
          fill_d   = '0;
          oldest_d = '0;
          newest_d = '0;
        end
        mavn_pkg::REG_NORMALISE_MODE: begin
          mode_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      fill_q      <= '0;
      oldest_q    <= '0;
      newest_q    <= '0;
      wl_q        <= WLW'(1);
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      newest_q    <= newest_d;
      wl_q        <= wl_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // taking a new word while the divider runs would corrupt it
  `ASSERT_IMPLY(a_ready_div_idle, clk_i, rst_ni, s_axis_tready_o, !div_busy)
  // between words the window never holds a full length of samples
  `ASSERT_IMPLY(a_fill_below_len, clk_i, rst_ni, state_q == ST_IDLE, CMP_W'(fill_q) < eff_len)
  // a finished division always lands in the output register
  `ASSERT_NEXT(a_finish_out, clk_i, rst_ni, finish, m_axis_tvalid_o && state_q == ST_IDLE)

endmodule

`default_nettype wire
